>>> hdl/mbrtu_pkg.sv
// shared types, constants and the crc-16 byte update for the modbus rtu receiver
// no dependencies; every other file in hdl imports this package
package mbrtu_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    // crc-16 (modbus): reflected polynomial, all-ones start value
    localparam t_word CRC_INIT = 16'hFFFF;
    localparam t_word CRC_POLY = 16'hA001;

    // function codes understood by the receiver
    localparam t_byte FC_READ_HOLDING  = 8'h03;
    localparam t_byte FC_WRITE_SINGLE  = 8'h06;
    localparam t_byte FC_WRITE_MULTI   = 8'h10;
    localparam t_byte FC_EXCEPTION_BIT = 8'h80;
    localparam t_byte EXC_ILLEGAL_FUNC = 8'h01;
    localparam t_byte ADDR_BROADCAST   = 8'h00;

    // header byte positions
    localparam logic [2:0] HDR_A_HI     = 3'd0;
    localparam logic [2:0] HDR_A_LO     = 3'd1;
    localparam logic [2:0] HDR_B_HI     = 3'd2;
    localparam logic [2:0] HDR_B_LO     = 3'd3;
    localparam logic [2:0] HDR_LEN_STD  = 3'd4;
    localparam logic [2:0] HDR_LEN_MULTI = 3'd5;

    // result kind
    localparam logic KIND_REQUEST   = 1'b0;
    localparam logic KIND_EXCEPTION = 1'b1;

    // queue between parser and word sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // parser phase
    typedef enum logic [2:0] {
        PH_ADDR,
        PH_FUNC,
        PH_HEAD,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    // exception frame byte position
    typedef enum logic [2:0] {
        TX_ADDR,
        TX_FUNC,
        TX_CODE,
        TX_CRC_LO,
        TX_CRC_HI
    } t_tx_step;

    // one queued job: a decoded request or an exception to transmit
    typedef struct packed {
        logic  kind;
        t_byte func;
        t_word word_a;
        t_word word_b;
        t_byte addr;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // one byte through the crc-16 update, bit at a time
    function automatic t_word crc_byte(input t_word crc, input t_byte b);
        t_word c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/mbrtu_in_if.sv
// received-byte channel: valid/ready handshake with byte or timeout event
// depends on mbrtu_pkg
interface mbrtu_in_if;
    import mbrtu_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  timed_out;

    modport source (output valid, output rx_byte, output timed_out, input ready);
    modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

>>> hdl/mbrtu_out_if.sv
// result channel: decoded requests and exception transmit bytes
// depends on mbrtu_pkg
interface mbrtu_out_if;
    import mbrtu_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    t_byte func_code;
    t_word first_word;
    t_word second_word;
    t_byte tx_byte;
    logic  last;

    modport source (
        output valid, output kind, output func_code, output first_word,
        output second_word, output tx_byte, output last, input ready
    );
    modport sink (
        input valid, input kind, input func_code, input first_word,
        input second_word, input tx_byte, input last, output ready
    );
endinterface

>>> hdl/mbrtu_cfg_if.sv
// configuration write channel carrying the node address
// depends on mbrtu_pkg
interface mbrtu_cfg_if;
    import mbrtu_pkg::*;

    logic  valid;
    logic  ready;
    t_byte own_address;

    modport source (output valid, output own_address, input ready);
    modport sink   (input valid, input own_address, output ready);
endinterface

>>> hdl/mbrtu_front.sv
// frame parser: address match, function decode, header capture and crc check
// depends on mbrtu_pkg; pushes jobs into mbrtu_queue
module mbrtu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mbrtu_pkg::t_byte      i_rx_byte,
    input  logic                  i_timed_out,
    input  mbrtu_pkg::t_byte      i_own_address,
    input  mbrtu_pkg::t_queue_status i_queue,
    output logic                  o_push,
    output mbrtu_pkg::t_cmd       o_cmd
);
    import mbrtu_pkg::*;

    t_phase     r_phase,     n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [2:0] r_hdr_idx,   n_hdr_idx;
    t_word      r_crc,       n_crc;
    t_byte      r_func,      n_func;
    t_word      r_word_a,    n_word_a;
    t_word      r_word_b,    n_word_b;
    t_byte      r_crc_low,   n_crc_low;

    logic       accept;
    logic       func_known;
    logic [2:0] hdr_need;

    assign o_ready    = !i_queue.full;
    assign accept     = i_valid && o_ready;
    assign func_known = (i_rx_byte == FC_READ_HOLDING) || (i_rx_byte == FC_WRITE_SINGLE)
                     || (i_rx_byte == FC_WRITE_MULTI);
    assign hdr_need   = (r_func == FC_WRITE_MULTI) ? HDR_LEN_MULTI : HDR_LEN_STD;

    // next state of the parser
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_hdr_idx    = r_hdr_idx;
        n_crc        = r_crc;
        n_func       = r_func;
        n_word_a     = r_word_a;
        n_word_b     = r_word_b;
        n_crc_low    = r_crc_low;
        if (accept) begin
            if (i_timed_out) begin
                n_phase      = PH_ADDR;
                n_crc        = CRC_INIT;
                n_hdr_idx    = '0;
                n_bytes_left = '0;
            end else begin
                unique case (r_phase)
                    PH_FUNC: begin
                        n_func = i_rx_byte;
                        if (func_known) begin
                            n_crc     = crc_byte(r_crc, i_rx_byte);
                            n_word_a  = '0;
                            n_word_b  = '0;
                            n_hdr_idx = '0;
                            n_phase   = PH_HEAD;
                        end else begin
                            n_phase      = PH_ADDR;
                            n_crc        = CRC_INIT;
                            n_hdr_idx    = '0;
                            n_bytes_left = '0;
                        end
                    end
                    PH_HEAD: begin
                        n_crc = crc_byte(r_crc, i_rx_byte);
                        unique case (r_hdr_idx)
                            HDR_A_HI: n_word_a = {i_rx_byte, 8'h00};
                            HDR_A_LO: n_word_a = {r_word_a[15:8], i_rx_byte};
                            HDR_B_HI: n_word_b = {i_rx_byte, 8'h00};
                            HDR_B_LO: n_word_b = {r_word_b[15:8], i_rx_byte};
                            default:  n_bytes_left = i_rx_byte;
                        endcase
                        n_hdr_idx = r_hdr_idx + 3'd1;
                        if (n_hdr_idx >= hdr_need) begin
                            if (hdr_need == HDR_LEN_MULTI && n_bytes_left != '0) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_CRC_LO;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_crc        = crc_byte(r_crc, i_rx_byte);
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (n_bytes_left == '0) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        n_crc_low = i_rx_byte;
                        n_phase   = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        n_phase      = PH_ADDR;
                        n_crc        = CRC_INIT;
                        n_hdr_idx    = '0;
                        n_bytes_left = '0;
                    end
                    default: begin
                        // waiting for an address byte, also any stray phase code
                        n_phase      = PH_ADDR;
                        n_crc        = CRC_INIT;
                        n_hdr_idx    = '0;
                        n_bytes_left = '0;
                        if (i_rx_byte == i_own_address || i_rx_byte == ADDR_BROADCAST) begin
                            n_crc   = crc_byte(CRC_INIT, i_rx_byte);
                            n_phase = PH_FUNC;
                        end
                    end
                endcase
            end
        end
    end

    // job to the queue: exception on unknown code, request on good crc
    always_comb begin
        o_push = 1'b0;
        if (accept && !i_timed_out) begin
            if (r_phase == PH_FUNC && !func_known) begin
                o_push = 1'b1;
            end else if (r_phase == PH_CRC_HI && {i_rx_byte, r_crc_low} == r_crc) begin
                o_push = 1'b1;
            end
        end
        o_cmd.kind   = (r_phase == PH_FUNC) ? KIND_EXCEPTION : KIND_REQUEST;
        o_cmd.func   = (r_phase == PH_FUNC) ? i_rx_byte : r_func;
        o_cmd.word_a = r_word_a;
        o_cmd.word_b = r_word_b;
        o_cmd.addr   = i_own_address;
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ADDR;
            r_bytes_left <= '0;
            r_hdr_idx    <= '0;
            r_crc        <= CRC_INIT;
            r_func       <= '0;
            r_word_a     <= '0;
            r_word_b     <= '0;
            r_crc_low    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_hdr_idx    <= n_hdr_idx;
            r_crc        <= n_crc;
            r_func       <= n_func;
            r_word_a     <= n_word_a;
            r_word_b     <= n_word_b;
            r_crc_low    <= n_crc_low;
        end
    end

endmodule

>>> hdl/mbrtu_queue.sv
// short show-ahead queue of jobs between parser and word sequencer
// depends on mbrtu_pkg
module mbrtu_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  mbrtu_pkg::t_cmd          i_cmd,
    input  logic                     i_pop,
    output mbrtu_pkg::t_cmd          o_cmd,
    output mbrtu_pkg::t_queue_status o_status
);
    import mbrtu_pkg::*;

    t_cmd                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count,  n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_entry[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/mbrtu_back.sv
// word sequencer: turns queued jobs into result words, five per exception frame
// depends on mbrtu_pkg; fed by mbrtu_queue
module mbrtu_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mbrtu_pkg::t_cmd          i_cmd,
    input  mbrtu_pkg::t_queue_status i_queue,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_kind,
    output mbrtu_pkg::t_byte         o_func_code,
    output mbrtu_pkg::t_word         o_first_word,
    output mbrtu_pkg::t_word         o_second_word,
    output mbrtu_pkg::t_byte         o_tx_byte,
    output logic                     o_last
);
    import mbrtu_pkg::*;

    t_tx_step r_step, n_step;
    t_word    r_crc,  n_crc;
    logic     r_valid;
    logic     r_kind;
    t_byte    r_func;
    t_word    r_word_a;
    t_word    r_word_b;
    t_byte    r_tx;
    logic     r_last;

    logic     load;
    logic     is_exc;
    t_byte    tx_now;
    logic     last_now;

    // output register free or being taken, and a job waiting
    assign load   = (!r_valid || i_ready) && !i_queue.empty;
    assign is_exc = (i_cmd.kind == KIND_EXCEPTION);

    // byte of the exception frame at the current step
    always_comb begin
        unique case (r_step)
            TX_ADDR:   tx_now = i_cmd.addr;
            TX_FUNC:   tx_now = i_cmd.func | FC_EXCEPTION_BIT;
            TX_CODE:   tx_now = EXC_ILLEGAL_FUNC;
            TX_CRC_LO: tx_now = r_crc[7:0];
            TX_CRC_HI: tx_now = r_crc[15:8];
            default:   tx_now = r_crc[15:8];
        endcase
    end

    // next step and running crc of the exception frame
    always_comb begin
        n_step = r_step;
        n_crc  = r_crc;
        if (load && is_exc) begin
            unique case (r_step)
                TX_ADDR: begin
                    n_crc  = crc_byte(CRC_INIT, tx_now);
                    n_step = TX_FUNC;
                end
                TX_FUNC: begin
                    n_crc  = crc_byte(r_crc, tx_now);
                    n_step = TX_CODE;
                end
                TX_CODE: begin
                    n_crc  = crc_byte(r_crc, tx_now);
                    n_step = TX_CRC_LO;
                end
                TX_CRC_LO: n_step = TX_CRC_HI;
                default:   n_step = TX_ADDR;
            endcase
        end
    end

    // pop at the end of a job
    always_comb begin
        last_now = !is_exc || (r_step == TX_CRC_HI);
        o_pop    = load && last_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= TX_ADDR;
            r_crc   <= CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_crc  <= n_crc;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_cmd.kind;
            r_func   <= i_cmd.func;
            r_word_a <= is_exc ? '0 : i_cmd.word_a;
            r_word_b <= is_exc ? '0 : i_cmd.word_b;
            r_tx     <= is_exc ? tx_now : '0;
            r_last   <= last_now;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_func_code   = r_func;
    assign o_first_word  = r_word_a;
    assign o_second_word = r_word_b;
    assign o_tx_byte     = r_tx;
    assign o_last        = r_last;

endmodule

>>> hdl/modbus_rtu_slave_frame_receiver.sv
// Modbus RTU slave request receiver. One received byte or timeout event is taken
// per clock cycle; the crc-16 update of a byte is done in that same cycle in the
// parser. A good frame for codes 0x03, 0x06 or 0x10 gives one result word when its
// last crc byte is taken; an unknown function code gives five exception words from
// the output sequencer. Between parser and sequencer sits a two-job queue, and a
// job stays in it until its last word is loaded into the output register. The
// input stays ready while the queue has room and stalls once it holds two jobs:
// behind a blocked output, or when unknown-code frames arrive faster than their
// five words drain. With an empty queue and a free output register, the job that
// a taken byte completes is written into the queue, then loaded into the output
// register, where its result word is valid and held until taken. The node address
// is written through the configuration channel, which is always ready; it resets to 1.
// depends on mbrtu_pkg, mbrtu_in_if, mbrtu_out_if, mbrtu_cfg_if, mbrtu_front,
// mbrtu_queue and mbrtu_back
module modbus_rtu_slave_frame_receiver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbrtu_in_if.sink      i_in,
    mbrtu_cfg_if.sink     i_cfg,
    mbrtu_out_if.source   o_out
);
    import mbrtu_pkg::*;

    t_byte         r_own_address;
    logic          push;
    logic          pop;
    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status queue_status;

    // node address register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 8'd1;
        end else if (i_cfg.valid) begin
            r_own_address <= i_cfg.own_address;
        end
    end

    // frame parser
    mbrtu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_rx_byte     (i_in.rx_byte),
        .i_timed_out   (i_in.timed_out),
        .i_own_address (r_own_address),
        .i_queue       (queue_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // job queue
    mbrtu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (queue_status)
    );

    // result word sequencer
    mbrtu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_queue       (queue_status),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_kind        (o_out.kind),
        .o_func_code   (o_out.func_code),
        .o_first_word  (o_out.first_word),
        .o_second_word (o_out.second_word),
        .o_tx_byte     (o_out.tx_byte),
        .o_last        (o_out.last)
    );

endmodule

>>> bench/modbus_rtu_slave_frame_receiver_tb.sv
// self-checking bench for the modbus rtu slave frame receiver: directed frames, then random
// traffic under several idle and stall patterns, checked word by word against a frame parser
// depends on mbrtu_pkg, mbrtu_in_if, mbrtu_cfg_if, mbrtu_out_if and the receiver itself
`timescale 1ns / 100ps

module modbus_rtu_slave_frame_receiver_tb;
    import mbrtu_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // one result word as the receiver should hand it out
    typedef struct {
        logic  kind;
        t_byte func;
        t_word word_a;
        t_word word_b;
        t_byte tx;
        logic  last;
    } t_reply_word;

    logic clk = 1'b0;
    logic rst_n;

    mbrtu_in_if  in_if ();
    mbrtu_cfg_if cfg_if ();
    mbrtu_out_if out_if ();

    modbus_rtu_slave_frame_receiver uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // parser copy kept by the bench
    t_byte      node_addr  = 8'd1;
    t_phase     rx_phase   = PH_ADDR;
    logic [8:0] data_left  = '0;
    logic [2:0] hdr_pos    = '0;
    t_word      frame_crc  = CRC_INIT;
    t_byte      frame_func = '0;
    t_word      hdr_word_a = '0;
    t_word      hdr_word_b = '0;
    t_byte      crc_lo_rx  = '0;

    t_reply_word awaited_words[$];
    t_byte       frame_buf[$];

    int send_idle_pct   = 0;
    int reply_stall_pct = 0;
    int words_sent      = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modbus_rtu_slave_frame_receiver_tb: errors");
            $finish;
        end
    end

    // crc-16 over one byte, lsb first, bit of the byte folded into the decision
    function automatic t_word crc16_modbus(input t_word crc, input t_byte b);
        t_word acc;
        acc = crc;
        for (int n = 0; n < 8; n++) begin
            acc = (acc >> 1) ^ ((acc[0] ^ b[n]) ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic logic is_known_func(input t_byte f);
        return (f == FC_READ_HOLDING) || (f == FC_WRITE_SINGLE) || (f == FC_WRITE_MULTI);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic expect_reply(input logic kind, input t_byte func, input t_word wa,
                                input t_word wb, input t_byte tx, input logic last);
        t_reply_word w;
        w.kind   = kind;
        w.func   = func;
        w.word_a = wa;
        w.word_b = wb;
        w.tx     = tx;
        w.last   = last;
        awaited_words.push_back(w);
    endtask

    task automatic restart_frame();
        rx_phase  = PH_ADDR;
        frame_crc = CRC_INIT;
        hdr_pos   = '0;
        data_left = '0;
    endtask

    // advance the parser copy by one accepted input word
    task automatic decode_rx_word(input t_byte b, input logic tmo);
        t_byte      fx;
        t_word      c;
        logic [2:0] need;
        if (tmo) begin
            restart_frame();
            return;
        end
        case (rx_phase)
            PH_FUNC: begin
                frame_func = b;
                if (is_known_func(b)) begin
                    frame_crc  = crc16_modbus(frame_crc, b);
                    hdr_word_a = '0;
                    hdr_word_b = '0;
                    hdr_pos    = '0;
                    rx_phase   = PH_HEAD;
                end else begin
                    // unknown code: five-byte exception frame
                    fx = b | FC_EXCEPTION_BIT;
                    c  = crc16_modbus(CRC_INIT, node_addr);
                    c  = crc16_modbus(c, fx);
                    c  = crc16_modbus(c, EXC_ILLEGAL_FUNC);
                    expect_reply(KIND_EXCEPTION, b, '0, '0, node_addr, 1'b0);
                    expect_reply(KIND_EXCEPTION, b, '0, '0, fx, 1'b0);
                    expect_reply(KIND_EXCEPTION, b, '0, '0, EXC_ILLEGAL_FUNC, 1'b0);
                    expect_reply(KIND_EXCEPTION, b, '0, '0, c[7:0], 1'b0);
                    expect_reply(KIND_EXCEPTION, b, '0, '0, c[15:8], 1'b1);
                    restart_frame();
                end
            end
            PH_HEAD: begin
                need      = (frame_func == FC_WRITE_MULTI) ? HDR_LEN_MULTI : HDR_LEN_STD;
                frame_crc = crc16_modbus(frame_crc, b);
                case (hdr_pos)
                    HDR_A_HI: hdr_word_a = {b, 8'h00};
                    HDR_A_LO: hdr_word_a = hdr_word_a | {8'h00, b};
                    HDR_B_HI: hdr_word_b = {b, 8'h00};
                    HDR_B_LO: hdr_word_b = hdr_word_b | {8'h00, b};
                    default:  data_left  = {1'b0, b};
                endcase
                hdr_pos = hdr_pos + 3'd1;
                if (hdr_pos >= need) begin
                    if (need == HDR_LEN_MULTI && data_left != 0) begin
                        rx_phase = PH_DATA;
                    end else begin
                        rx_phase = PH_CRC_LO;
                    end
                end
            end
            PH_DATA: begin
                frame_crc = crc16_modbus(frame_crc, b);
                data_left = data_left - 9'd1;
                if (data_left == 0) begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                crc_lo_rx = b;
                rx_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                if ({b, crc_lo_rx} == frame_crc) begin
                    expect_reply(KIND_REQUEST, frame_func, hdr_word_a, hdr_word_b, '0, 1'b1);
                end
                restart_frame();
            end
            default: begin
                // address byte, also any stray phase code
                restart_frame();
                if (b == node_addr || b == ADDR_BROADCAST) begin
                    frame_crc = crc16_modbus(frame_crc, b);
                    rx_phase  = PH_FUNC;
                end
            end
        endcase
    endtask

    // one input word: optional idle gap, then hold until taken
    task automatic send_word(input t_byte b, input logic tmo);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid     <= 1'b1;
        in_if.rx_byte   <= b;
        in_if.timed_out <= tmo;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        decode_rx_word(b, tmo);
        words_sent++;
    endtask

    // sender holds off until every awaited word is out
    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (awaited_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_address(input t_byte a);
        wait_results_drained();
        cfg_if.valid       <= 1'b1;
        cfg_if.own_address <= a;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        node_addr = a;
    endtask

    // request body without crc into frame_buf
    task automatic load_request(input t_byte addr, input t_byte func, input t_word wa,
                                input t_word wb, input t_byte count);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(func);
        frame_buf.push_back(wa[15:8]);
        frame_buf.push_back(wa[7:0]);
        frame_buf.push_back(wb[15:8]);
        frame_buf.push_back(wb[7:0]);
        if (func == FC_WRITE_MULTI) begin
            frame_buf.push_back(count);
            repeat (count) frame_buf.push_back(t_byte'($urandom));
        end
    endtask

    // append crc (one bit flipped when bad_crc) and send the whole frame
    task automatic send_frame_buf(input logic bad_crc);
        t_word crc;
        crc = CRC_INIT;
        foreach (frame_buf[i]) crc = crc16_modbus(crc, frame_buf[i]);
        if (bad_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        foreach (frame_buf[i]) send_word(frame_buf[i], 1'b0);
    endtask

    function automatic t_byte pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 80) return node_addr;
        if (r < 95) return ADDR_BROADCAST;
        return t_byte'($urandom);
    endfunction

    function automatic t_byte pick_request_func();
        case ($urandom_range(2))
            0:       return FC_READ_HOLDING;
            1:       return FC_WRITE_SINGLE;
            default: return FC_WRITE_MULTI;
        endcase
    endfunction

    // mostly well-formed frames, some exceptions, truncations and line noise
    task automatic run_random_traffic(input int word_budget);
        int    start_count;
        int    pick;
        int    cut;
        t_byte f;
        start_count = words_sent;
        while (words_sent - start_count < word_budget) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                load_request(pick_address(), pick_request_func(), t_word'($urandom),
                             t_word'($urandom),
                             ($urandom_range(29) == 0) ? 8'hFF : t_byte'($urandom_range(6)));
                send_frame_buf($urandom_range(99) < 15);
            end else if (pick < 72) begin
                do f = t_byte'($urandom); while (is_known_func(f));
                send_word(pick_address(), 1'b0);
                send_word(f, 1'b0);
            end else if (pick < 84) begin
                // frame cut short by an inter-byte timeout
                load_request(pick_address(), pick_request_func(), t_word'($urandom),
                             t_word'($urandom), t_byte'($urandom_range(4)));
                cut = $urandom_range(1, frame_buf.size());
                for (int i = 0; i < cut; i++) send_word(frame_buf[i], 1'b0);
                send_word(t_byte'($urandom), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(t_byte'($urandom), $urandom_range(7) == 0);
                end
                send_word(t_byte'($urandom), 1'b1);
            end
            if ($urandom_range(39) == 0) begin
                wait_results_drained();
            end
        end
    endtask

    // frame rules with the reset address: foreign, broadcast unknown code, zero count, timeout, bad crc
    task automatic test_frame_rules();
        send_word(8'hFF, 1'b0);
        send_word(ADDR_BROADCAST, 1'b0);
        send_word(8'hFF, 1'b0);
        load_request(node_addr, FC_WRITE_MULTI, 16'hFFFF, 16'h0000, 8'h00);
        send_frame_buf(1'b0);
        send_word(node_addr, 1'b0);
        send_word(FC_WRITE_SINGLE, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(t_byte'($urandom), 1'b1);
        load_request(node_addr, FC_READ_HOLDING, 16'h0000, 16'hFFFF, 8'h00);
        send_frame_buf(1'b1);
    endtask

    task automatic test_steady_flow();
        write_own_address(8'd247);
        send_idle_pct   = 0;
        reply_stall_pct = 0;
        run_random_traffic(100);
    endtask

    task automatic test_sparse_sender();
        write_own_address(8'd0);
        send_idle_pct   = 87;
        reply_stall_pct = 0;
        run_random_traffic(50);
        wait_results_drained();
        run_random_traffic(50);
    endtask

    task automatic test_slow_receiver();
        write_own_address(t_byte'($urandom_range(2, 246)));
        send_idle_pct   = 0;
        reply_stall_pct = 87;
        run_random_traffic(100);
    endtask

    task automatic test_both_idle();
        write_own_address(8'd1);
        send_idle_pct   = 6;
        reply_stall_pct = 6;
        run_random_traffic(100);
    endtask

    // result side: random ready, compare each taken word with the oldest awaited one
    initial begin
        t_reply_word want;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (awaited_words.size() == 0) begin
                    note_error($sformatf(
                        "unexpected word kind=%0b func=%02h a=%04h b=%04h tx=%02h last=%0b",
                        out_if.kind, out_if.func_code, out_if.first_word,
                        out_if.second_word, out_if.tx_byte, out_if.last));
                end else begin
                    want = awaited_words.pop_front();
                    if (out_if.kind !== want.kind)
                        note_error($sformatf("kind: expected %0b got %0b",
                                             want.kind, out_if.kind));
                    if (out_if.func_code !== want.func)
                        note_error($sformatf("func_code: expected %02h got %02h",
                                             want.func, out_if.func_code));
                    if (out_if.first_word !== want.word_a)
                        note_error($sformatf("first_word: expected %04h got %04h",
                                             want.word_a, out_if.first_word));
                    if (out_if.second_word !== want.word_b)
                        note_error($sformatf("second_word: expected %04h got %04h",
                                             want.word_b, out_if.second_word));
                    if (out_if.tx_byte !== want.tx)
                        note_error($sformatf("tx_byte: expected %02h got %02h",
                                             want.tx, out_if.tx_byte));
                    if (out_if.last !== want.last)
                        note_error($sformatf("last: expected %0b got %0b",
                                             want.last, out_if.last));
                end
            end
            out_if.ready <= ($urandom_range(99) >= reply_stall_pct);
        end
    end

    // reset, tests in turn, final verdict
    initial begin
        in_if.valid        <= 1'b0;
        in_if.rx_byte      <= '0;
        in_if.timed_out    <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.own_address <= '0;
        rst_n              <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_frame_rules();
        test_steady_flow();
        test_sparse_sender();
        test_slow_receiver();
        test_both_idle();

        // drain, then watch for stray words
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("modbus_rtu_slave_frame_receiver_tb: clean");
        end else begin
            $display("modbus_rtu_slave_frame_receiver_tb: errors");
        end
        $finish;
    end

endmodule

>>> modbus_rtu_slave_frame_receiver.f
hdl/mbrtu_pkg.sv
hdl/mbrtu_in_if.sv
hdl/mbrtu_out_if.sv
hdl/mbrtu_cfg_if.sv
hdl/mbrtu_front.sv
hdl/mbrtu_queue.sv
hdl/mbrtu_back.sv
hdl/modbus_rtu_slave_frame_receiver.sv
bench/modbus_rtu_slave_frame_receiver_tb.sv
